@@ rtl/core/mexp_pkg.sv @@
// package for the modular exponentiation block
// shared constants, register indexes and the controller/datapath command and status types
// no dependencies
package mexp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_MUL,
		OP_SQR
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    start;
		mul_op_t op;
		logic    wb_base;
		logic    wb_acc;
		logic    shift_exp;
		logic    out_load;
	} mexp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_zero;
		logic exp_lsb;
	} mexp_sts_t;

endpackage

@@ rtl/core/mexp_if.sv @@
// valid/ready stream interfaces for the base input and the result output
// depends on nothing; width set by parameter
interface mexp_in_if #(parameter int WIDTH = 32);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] base;

	modport source (output valid, output base, input ready);
	modport sink   (input valid, input base, output ready);
endinterface

interface mexp_out_if #(parameter int WIDTH = 32);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

@@ rtl/core/mexp_mulmod.sv @@
// shift-add modular multiplier, one multiplier bit per cycle
// a zero modulus stands for 2^WIDTH (products wrap); self-contained
module mexp_mulmod #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] product
);

	localparam int CNT_W = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             m_zero;
	logic             last;
	logic [WIDTH-1:0] dbl;
	logic [WIDTH-1:0] acc_nxt;

	function automatic logic [WIDTH-1:0] add_mod(
		input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y,
		input logic [WIDTH-1:0] md,
		input logic             mz
	);
		logic [WIDTH:0] sum;
		logic [WIDTH:0] diff;
		sum  = {1'b0, x} + {1'b0, y};
		diff = sum - {1'b0, md};
		if (mz)
			return sum[WIDTH-1:0];
		else if (sum >= {1'b0, md})
			return diff[WIDTH-1:0];
		else
			return sum[WIDTH-1:0];
	endfunction

	assign m_zero  = (m == '0);
	assign last    = (cnt_q == CNT_W'(WIDTH - 1));
	assign dbl     = add_mod(acc_q, acc_q, m, m_zero);
	assign acc_nxt = a_q[WIDTH-1] ? add_mod(dbl, b_q, m, m_zero) : dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q & last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[WIDTH-2:0], 1'b0};
			acc_q <= acc_nxt;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ rtl/core/mexp_datapath.sv @@
// datapath: configuration registers, base/accumulator/exponent registers, result register
// depends on mexp_pkg and mexp_mulmod
module mexp_datapath #(
	parameter int WIDTH = mexp_pkg::DATA_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [WIDTH-1:0]               cfg_wdata,
	input  logic [WIDTH-1:0]               in_base,
	input  mexp_pkg::mexp_cmd_t            cmd,
	output mexp_pkg::mexp_sts_t            sts,
	output logic [WIDTH-1:0]               result
);

	import mexp_pkg::*;

	logic [WIDTH-1:0] exp_cfg_q;
	logic [WIDTH-1:0] mod_cfg_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] result_q;
	logic [WIDTH-1:0] mul_a;
	logic [WIDTH-1:0] mul_b;
	logic [WIDTH-1:0] product;
	logic             mul_done;

	always_comb begin
		case (cmd.op)
			OP_REDUCE: begin
				mul_a = base_q;
				mul_b = WIDTH'(1);
			end
			OP_MUL: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = base_q;
				mul_b = base_q;
			end
		endcase
	end

	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (mod_cfg_q),
		.done    (mul_done),
		.product (product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cfg_q <= '0;
			mod_cfg_q <= WIDTH'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_EXPONENT: exp_cfg_q <= cfg_wdata;
				REG_MODULUS:  mod_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= in_base;
			acc_q  <= WIDTH'(1);
			exp_q  <= exp_cfg_q;
		end else begin
			if (cmd.wb_base)
				base_q <= product;
			if (cmd.wb_acc)
				acc_q <= product;
			if (cmd.shift_exp)
				exp_q <= exp_q >> 1;
		end
		if (cmd.out_load)
			result_q <= acc_q;
	end

	assign sts.mul_done = mul_done;
	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_lsb  = exp_q[0];
	assign result       = result_q;

endmodule

@@ rtl/core/mexp_ctrl.sv @@
// controller: sequences reduction, multiply and square steps over the exponent bits
// depends on mexp_pkg
module mexp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mexp_pkg::mexp_sts_t sts,
	output mexp_pkg::mexp_cmd_t cmd
);

	import mexp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_RED   = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_SQR   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_PREP;
				end
			end
			S_PREP: begin
				if (sts.exp_zero) begin
					state_nxt = S_OUT;
				end else begin
					cmd.start = 1'b1;
					cmd.op    = OP_REDUCE;
					state_nxt = S_RED;
				end
			end
			S_RED: begin
				cmd.op = OP_REDUCE;
				if (sts.mul_done) begin
					cmd.wb_base = 1'b1;
					state_nxt   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.exp_zero) begin
					state_nxt = S_OUT;
				end else if (sts.exp_lsb) begin
					cmd.start = 1'b1;
					cmd.op    = OP_MUL;
					state_nxt = S_MUL;
				end else begin
					cmd.start = 1'b1;
					cmd.op    = OP_SQR;
					state_nxt = S_SQR;
				end
			end
			S_MUL: begin
				if (sts.mul_done) begin
					cmd.wb_acc = 1'b1;
					cmd.start  = 1'b1;
					cmd.op     = OP_SQR;
					state_nxt  = S_SQR;
				end else begin
					cmd.op = OP_MUL;
				end
			end
			S_SQR: begin
				cmd.op = OP_SQR;
				if (sts.mul_done) begin
					cmd.wb_base   = 1'b1;
					cmd.shift_exp = 1'b1;
					state_nxt     = S_CHECK;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/modular_exponentiation_top.sv @@
// top level of the modular exponentiation block: controller, datapath and stream ports
// depends on mexp_pkg, mexp_if, mexp_ctrl, mexp_datapath
//
// Each base beat gives one result beat: base raised to the exponent register, modulo the
// modulus register, by right-to-left square-and-multiply on one shared shift-add modular
// multiplier that handles one multiplier bit per cycle. Each item goes through an initial
// reduction of the base, then, for every exponent bit up to the highest set one, a square,
// with a multiply before it when the bit is set. A zero exponent gives 1. A zero modulus
// means 2^WIDTH. One item is in work at a time; a finished result waits in the output
// register while the next base is taken. Registers: exponent at index 0, modulus at index
// 1. The user must see that they are written only while the block is idle; the block
// itself does not enforce this.
module modular_exponentiation_top #(
	parameter int WIDTH = mexp_pkg::DATA_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [WIDTH-1:0]               cfg_wdata,
	mexp_in_if.sink                        in_ch,
	mexp_out_if.source                     out_ch
);

	import mexp_pkg::*;

	mexp_cmd_t        cmd;
	mexp_sts_t        sts;
	logic [WIDTH-1:0] result;
	logic             in_ready;
	logic             out_valid;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_datapath #(
		.WIDTH(WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_base   (in_ch.base),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

	assign in_ch.ready   = in_ready;
	assign out_ch.valid  = out_valid;
	assign out_ch.result = result;

endmodule

@@ rtl/core/mexp_checker.sv @@
// port-level checks for modular_exponentiation_top, attached by bind
// depends on modular_exponentiation_top and its stream interfaces
module mexp_checker #(
	parameter int WIDTH = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [WIDTH-1:0] out_result
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 2'd0;
		else if (in_acc && !out_acc)
			pend_q <= pend_q + 2'd1;
		else if (out_acc && !in_acc)
			pend_q <= pend_q - 2'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_result))
		else $error("result beat dropped or changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result beat without a matching base beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pend_q == 2'd0 || (pend_q == 2'd1 && out_valid))
		else $error("base beat taken while an item is still in work");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("base beat taken in consecutive cycles");

endmodule

bind modular_exponentiation_top mexp_checker #(
	.WIDTH(WIDTH)
) u_mexp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_result (out_ch.result)
);

@@ sim/modular_exponentiation_top_tb.sv @@
// self-checking testbench for modular_exponentiation_top: directed and random bases under
// several exponent/modulus settings, results checked against a square-and-multiply predictor
// depends on mexp_pkg, mexp_if and the rtl of modular_exponentiation_top
module modular_exponentiation_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	localparam int W          = DATA_WIDTH;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int DRAIN_WAIT  = 2400;

	typedef struct packed {
		logic [W-1:0] base;
		logic [W-1:0] result;
	} power_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [W-1:0]         cfg_wdata;

	mexp_in_if  #(.WIDTH(W)) base_ch ();
	mexp_out_if #(.WIDTH(W)) res_ch ();

	modular_exponentiation_top #(.WIDTH(W)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (base_ch),
		.out_ch    (res_ch)
	);

	power_t       pending_powers[$];
	logic [W-1:0] cur_exponent;
	logic [W-1:0] cur_modulus;
	int           error_count;
	int           tx_idle_pct;
	int           rx_idle_pct;
	int           hold_request;
	int           hold_left;
	int           cycle_count;

	function automatic logic [W-1:0] mulmod(input logic [W-1:0] a, input logic [W-1:0] b,
	                                        input logic [W-1:0] m);
		logic [2*W-1:0] prod;
		prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
		if (m == '0)
			return prod[W-1:0];
		return W'(prod % {{W{1'b0}}, m});
	endfunction

	// right-to-left square and multiply, zero modulus stands for 2^W
	function automatic logic [W-1:0] modpow(input logic [W-1:0] base, input logic [W-1:0] e,
	                                        input logic [W-1:0] m);
		logic [W-1:0] acc;
		logic [W-1:0] sq;
		if (e == '0)
			return W'(1);
		if (m == '0) begin
			acc = W'(1);
			sq  = base;
		end else begin
			acc = W'(1) % m;
			sq  = base % m;
		end
		for (int i = 0; i < W; i++) begin
			if (e[i])
				acc = mulmod(acc, sq, m);
			sq = mulmod(sq, sq, m);
		end
		return acc;
	endfunction

	task automatic report_mismatch(input string what, input logic [W-1:0] base,
	                               input logic [W-1:0] got, input logic [W-1:0] want);
		$display("[%0t] mismatch: %s base=%h got=%h expected=%h", $realtime, what, base, got,
		         want);
		error_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_EXPONENT)
			cur_exponent = value;
		else if (idx == REG_MODULUS)
			cur_modulus = value;
	endtask

	task automatic wait_idle();
		while (pending_powers.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_key(input logic [W-1:0] e, input logic [W-1:0] m);
		wait_idle();
		write_reg(REG_EXPONENT, e);
		write_reg(REG_MODULUS, m);
	endtask

	task automatic send_base(input logic [W-1:0] base);
		power_t item;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			base_ch.valid <= 1'b0;
			@(negedge clk);
		end
		base_ch.valid <= 1'b1;
		base_ch.base  <= base;
		@(posedge clk);
		while (!base_ch.ready)
			@(posedge clk);
		item.base   = base;
		item.result = modpow(base, cur_exponent, cur_modulus);
		pending_powers.push_back(item);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		base_ch.valid <= 1'b0;
	endtask

	function automatic logic [W-1:0] rand_exponent();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return W'(1) << $urandom_range(0, W-1);
			default: return W'($urandom) >> $urandom_range(0, W-1);
		endcase
	endfunction

	function automatic logic [W-1:0] rand_modulus();
		case ($urandom_range(0, 11))
			0:       return W'(1);
			1:       return '0;
			2:       return '1;
			3:       return W'(1) << $urandom_range(1, W-1);
			4, 5:    return W'($urandom_range(2, 1000));
			6:       return W'($urandom) >> $urandom_range(0, W-1);
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic [W-1:0] rand_base();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return cur_modulus;
			3:       return cur_modulus - W'(1);
			4:       return W'($urandom_range(0, 3));
			default: return W'($urandom);
		endcase
	endfunction

	task automatic test_reset_values();
		send_base('0);
		send_base('1);
		stop_sending();
	endtask

	task automatic test_zero_exponent();
		set_key('0, '1);
		send_base('0);
		send_base(W'(1));
		send_base('1);
		stop_sending();
		set_key('0, '0);
		send_base(W'(32'h1234_5678));
		stop_sending();
	endtask

	task automatic test_modulus_one();
		set_key('1, W'(1));
		send_base('1);
		send_base(W'(7));
		stop_sending();
	endtask

	task automatic test_zero_modulus();
		set_key(W'(32'h0001_0001), '0);
		send_base('1);
		send_base(W'(32'h1234_5678));
		send_base('0);
		stop_sending();
	endtask

	task automatic test_full_width();
		set_key('1, '1);
		send_base('0);
		send_base(W'(1));
		send_base('1 - W'(1));
		send_base('1);
		stop_sending();
	endtask

	task automatic test_small_key();
		set_key(W'(17), W'(3233));
		send_base(W'(65));
		send_base(W'(3233));
		send_base(W'(3232));
		send_base(W'(4000));
		stop_sending();
	endtask

	// receiver holds off so the block fills and stalls its input beat
	task automatic test_back_pressure();
		tx_idle_pct = 0;
		set_key(W'(5), W'($urandom) | W'(1));
		@(negedge clk);
		hold_request = 1500;
		for (int i = 0; i < 8; i++)
			send_base(rand_base());
		stop_sending();
		wait_idle();
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 12 == 0) begin
				stop_sending();
				set_key(rand_exponent(), rand_modulus());
			end
			send_base(rand_base());
		end
		stop_sending();
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		res_ch.ready = 1'b0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		power_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_powers.size() == 0) begin
				report_mismatch("result beat with nothing pending", 'x, res_ch.result, 'x);
			end else begin
				want = pending_powers.pop_front();
				if (res_ch.result !== want.result)
					report_mismatch("result", want.base, res_ch.result, want.result);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_wdata     = '0;
		base_ch.valid = 1'b0;
		base_ch.base  = '0;
		error_count   = 0;
		hold_request  = 0;
		tx_idle_pct   = 20;
		rx_idle_pct   = 20;
		cur_exponent  = '0;
		cur_modulus   = W'(1);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_zero_exponent();
		test_modulus_one();
		test_zero_modulus();
		test_full_width();
		test_small_key();
		test_back_pressure();
		test_random_phase(38, 85, 87);
		test_random_phase(85, 38, 87);
		test_random_phase(0, 0, 87);

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		while (pending_powers.size() != 0) begin
			report_mismatch("result never arrived", pending_powers[0].base, 'x,
			                pending_powers[0].result);
			void'(pending_powers.pop_front());
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
